>>> sv/apt_pkg.sv
// Package for the affine point transform: widths, types, codes and reset values.
`default_nettype none

package apt_pkg;

    localparam int COEF_W  = 20;
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = COEF_W + COORD_W;
    localparam int TRANS_W = COORD_W + FRAC_W;
    localparam int SUM_W   = PROD_W + 4;
    localparam int QUO_W   = SUM_W - FRAC_W;
    localparam int COL_W   = 3 * COEF_W;
    localparam int CFG_W   = COL_W;
    localparam int IDX_W   = 3;
    localparam int KIND_W  = 2;

    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [TRANS_W-1:0] trans_t;
    typedef logic        [COL_W-1:0]   column_t;
    typedef logic        [KIND_W-1:0]  kind_t;
    typedef logic        [IDX_W-1:0]   cfg_index_t;

    typedef struct packed {
        coord_t value;
        logic   clip;
    } row_out_t;

    localparam kind_t KIND_AFFINE    = 2'd0;
    localparam kind_t KIND_LINEAR    = 2'd1;
    localparam kind_t KIND_TRANSPOSE = 2'd2;

    localparam cfg_index_t REG_COLUMN_ZERO = 3'd0;
    localparam cfg_index_t REG_COLUMN_ONE  = 3'd1;
    localparam cfg_index_t REG_COLUMN_TWO  = 3'd2;
    localparam cfg_index_t REG_SHIFT_X     = 3'd3;
    localparam cfg_index_t REG_SHIFT_Y     = 3'd4;
    localparam cfg_index_t REG_SHIFT_Z     = 3'd5;

    localparam coef_t   COEF_ONE      = coef_t'(1) <<< FRAC_W;
    localparam column_t COL_ZERO_INIT = column_t'(COEF_ONE);
    localparam column_t COL_ONE_INIT  = column_t'(COEF_ONE) << COEF_W;
    localparam column_t COL_TWO_INIT  = column_t'(COEF_ONE) << (2 * COEF_W);

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

`default_nettype wire

>>> sv/apt_row.sv
// One output coordinate: sum of three products and translation, floor shift, saturate.
`default_nettype none

module apt_row
(
    input  apt_pkg::prod_t    prod [3],
    input  apt_pkg::trans_t   trans,
    output apt_pkg::row_out_t row_out
);

    logic signed [apt_pkg::SUM_W-1:0] sum;
    logic signed [apt_pkg::QUO_W-1:0] quo;
    logic                             in_range;

    always_comb
    begin
        sum = apt_pkg::SUM_W'(prod[0]) + apt_pkg::SUM_W'(prod[1])
            + apt_pkg::SUM_W'(prod[2]) + apt_pkg::SUM_W'(trans);
        quo = sum[apt_pkg::SUM_W-1:apt_pkg::FRAC_W];
        in_range = (&quo[apt_pkg::QUO_W-1:apt_pkg::COORD_W-1])
                 | ~(|quo[apt_pkg::QUO_W-1:apt_pkg::COORD_W-1]);
        if (in_range)
        begin
            row_out.value = quo[apt_pkg::COORD_W-1:0];
            row_out.clip  = 1'b0;
        end
        else
        begin
            row_out.value = quo[apt_pkg::QUO_W-1] ? apt_pkg::COORD_MIN : apt_pkg::COORD_MAX;
            row_out.clip  = 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> sv/affine_point_transform.sv
// Top level of the affine point transform: config registers and three-stage pipeline.
// Takes one point per clock and returns one result per clock while the output is not
// stalled. The pipe is an input register, a register
// after the nine parallel 20x32 coefficient-point multipliers, and a result register
// after the per-row add, floor shift and saturation. Mode 0 gives A*p+t, mode 1 A*p,
// modes 2 and 3 give A^T*p. After reset A is the identity and t is zero. Matrix and
// translation writes take effect at once, so make them only while the pipe is empty.
`default_nettype none

module affine_point_transform
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_write,
    input  apt_pkg::cfg_index_t            cfg_index,
    input  logic [apt_pkg::CFG_W-1:0]      cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  apt_pkg::kind_t                 kind,
    input  logic signed [apt_pkg::COORD_W-1:0] point_x,
    input  logic signed [apt_pkg::COORD_W-1:0] point_y,
    input  logic signed [apt_pkg::COORD_W-1:0] point_z,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [apt_pkg::COORD_W-1:0] result_x,
    output logic signed [apt_pkg::COORD_W-1:0] result_y,
    output logic signed [apt_pkg::COORD_W-1:0] result_z,
    output logic                           saturated
);

    apt_pkg::column_t  col_reg [3];
    apt_pkg::coord_t   shift_reg [3];

    logic              v1_reg, v2_reg, v3_reg;
    logic              en1, en2, en3;

    apt_pkg::kind_t    kind_reg;
    apt_pkg::coord_t   point_reg [3];

    apt_pkg::prod_t    prod_next [3][3];
    apt_pkg::prod_t    prod_reg  [3][3];
    apt_pkg::trans_t   trans_next [3];
    apt_pkg::trans_t   trans_reg  [3];

    apt_pkg::row_out_t row_out [3];
    apt_pkg::coord_t   result_reg [3];
    logic              sat_reg;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg[0]   <= apt_pkg::COL_ZERO_INIT;
            col_reg[1]   <= apt_pkg::COL_ONE_INIT;
            col_reg[2]   <= apt_pkg::COL_TWO_INIT;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                apt_pkg::REG_COLUMN_ZERO: col_reg[0]   <= cfg_data;
                apt_pkg::REG_COLUMN_ONE:  col_reg[1]   <= cfg_data;
                apt_pkg::REG_COLUMN_TWO:  col_reg[2]   <= cfg_data;
                apt_pkg::REG_SHIFT_X:     shift_reg[0] <= cfg_data[apt_pkg::COORD_W-1:0];
                apt_pkg::REG_SHIFT_Y:     shift_reg[1] <= cfg_data[apt_pkg::COORD_W-1:0];
                apt_pkg::REG_SHIFT_Z:     shift_reg[2] <= cfg_data[apt_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // pipe control
    assign en3      = !v3_reg || !out_stall;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // stage 1: input register
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            kind_reg     <= kind;
            point_reg[0] <= point_x;
            point_reg[1] <= point_y;
            point_reg[2] <= point_z;
        end
    end

    // stage 2: coefficient select and multiply
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = (kind_reg[1]
                    ? apt_pkg::coef_t'(col_reg[r][apt_pkg::COEF_W*c +: apt_pkg::COEF_W])
                    : apt_pkg::coef_t'(col_reg[c][apt_pkg::COEF_W*r +: apt_pkg::COEF_W]))
                    * point_reg[c];
            end
            trans_next[r] = (kind_reg == apt_pkg::KIND_AFFINE)
                ? {shift_reg[r], {apt_pkg::FRAC_W{1'b0}}} : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            prod_reg  <= prod_next;
            trans_reg <= trans_next;
        end
    end

    // stage 3: sum, shift, saturate
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        apt_row u_row
        (
            .prod    (prod_reg[r]),
            .trans   (trans_reg[r]),
            .row_out (row_out[r])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            result_reg[0] <= row_out[0].value;
            result_reg[1] <= row_out[1].value;
            result_reg[2] <= row_out[2].value;
            sat_reg       <= row_out[0].clip | row_out[1].clip | row_out[2].clip;
        end
    end

    assign out_valid = v3_reg;
    assign result_x  = result_reg[0];
    assign result_y  = result_reg[1];
    assign result_z  = result_reg[2];
    assign saturated = sat_reg;

    // checks
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && out_stall))
        else $error("input stalled with a free pipe slot");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> (v1_reg && $stable(kind_reg) && $stable(point_reg[0])))
        else $error("stage 1 beat lost while stalled");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !en3) |=> (v2_reg && $stable(prod_reg[0][0]) && $stable(trans_reg[2])))
        else $error("stage 2 beat lost while stalled");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (result_x == apt_pkg::COORD_MAX || result_x == apt_pkg::COORD_MIN ||
             result_y == apt_pkg::COORD_MAX || result_y == apt_pkg::COORD_MIN ||
             result_z == apt_pkg::COORD_MAX || result_z == apt_pkg::COORD_MIN))
        else $error("saturation flag without a clipped coordinate");

endmodule

`default_nettype wire
